>>> sv/sfs_pkg.sv
// Shared widths, command codes and fault codes for the safety fault supervisor.
`default_nettype none
package sfs_pkg;

  localparam int CMD_W   = 3;
  localparam int TICK_W  = 32;
  localparam int FAULT_W = 3;

  localparam logic [CMD_W-1:0] CMD_BEAT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ESTOP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POWER  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DRIVER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

  localparam logic [FAULT_W-1:0] FLT_NONE   = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_ESTOP  = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_DRIVER = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_LOWBAT = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_COMM   = 3'd4;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd50;

endpackage
`default_nettype wire

>>> sv/sfs_ifs.sv
// Valid/ready channel interfaces for supervisor commands and status results.
`default_nettype none
interface sfs_cmd_if;
  import sfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [TICK_W-1:0]  tick_count;
  logic               flag_value;

  modport source (output valid, output cmd, output tick_count, output flag_value, input ready);
  modport sink   (input valid, input cmd, input tick_count, input flag_value, output ready);
endinterface

interface sfs_res_if;
  import sfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [FAULT_W-1:0] fault_code;
  logic [FAULT_W-1:0] latched_code;
  logic               stop_latched;
  logic               link_lost;
  logic               motion_ok;

  modport source (output valid, output fault_code, output latched_code,
                  output stop_latched, output link_lost, output motion_ok, input ready);
  modport sink   (input valid, input fault_code, input latched_code,
                  input stop_latched, input link_lost, input motion_ok, output ready);
endinterface
`default_nettype wire

>>> sv/safety_fault_supervisor.sv
// Safety fault supervisor: latched fault interlock with heartbeat watchdog.
// The result of an accepted request is registered and valid in the following cycle.
// Throughput: one request per cycle while results are taken; the single output register is refilled
// in the same cycle it is taken, so input ready = !result valid | result ready.
// Reset (rst, synchronous): all flags and the latch cleared, last heartbeat 0,
// timeout register 50, no result pending.
`default_nettype none
module safety_fault_supervisor (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        hb_timeout_we,
  input  wire [sfs_pkg::TICK_W-1:0]  hb_timeout_wdata,
  sfs_cmd_if.sink                    command,
  sfs_res_if.source                  status
);
  import sfs_pkg::*;

  logic [TICK_W-1:0]  hb_timeout;
  logic               estop_on, driver_bad, power_low, comm_lost, latch_set;
  logic [FAULT_W-1:0] latch_code;
  logic [TICK_W-1:0]  last_beat;

  logic               estop_on_next, driver_bad_next, power_low_next, comm_lost_next;
  logic               latch_set_next;
  logic [FAULT_W-1:0] latch_code_next, fault_next;
  logic [TICK_W-1:0]  last_beat_next, elapsed;
  logic               accept, hard_fault;

  assign command.ready = !status.valid || status.ready;
  assign accept        = command.valid && command.ready;
  assign elapsed       = command.tick_count - last_beat;

  always_comb begin
    estop_on_next   = estop_on;
    driver_bad_next = driver_bad;
    power_low_next  = power_low;
    comm_lost_next  = comm_lost;
    latch_set_next  = latch_set;
    latch_code_next = latch_code;
    last_beat_next  = last_beat;
    case (command.cmd)
      CMD_BEAT: begin
        last_beat_next = command.tick_count;
        comm_lost_next = 1'b0;
      end
      CMD_ESTOP:  estop_on_next   = command.flag_value;
      CMD_POWER:  power_low_next  = command.flag_value;
      CMD_DRIVER: driver_bad_next = command.flag_value;
      CMD_CLEAR: begin
        if (!estop_on && !driver_bad && !power_low) begin
          latch_set_next  = 1'b0;
          latch_code_next = FLT_NONE;
        end
      end
      CMD_TICK: begin
        if (elapsed > hb_timeout) begin
          comm_lost_next = 1'b1;
        end
      end
      default: ;
    endcase

    // priority re-evaluation; hard faults latch
    hard_fault = estop_on_next || driver_bad_next || power_low_next;
    if (estop_on_next) begin
      fault_next = FLT_ESTOP;
    end else if (driver_bad_next) begin
      fault_next = FLT_DRIVER;
    end else if (power_low_next) begin
      fault_next = FLT_LOWBAT;
    end else if (comm_lost_next) begin
      fault_next = FLT_COMM;
    end else if (latch_set_next) begin
      fault_next = latch_code_next;
    end else begin
      fault_next = FLT_NONE;
    end
    if (hard_fault) begin
      latch_set_next  = 1'b1;
      latch_code_next = fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_timeout   <= TIMEOUT_RESET;
      estop_on     <= 1'b0;
      driver_bad   <= 1'b0;
      power_low    <= 1'b0;
      comm_lost    <= 1'b0;
      latch_set    <= 1'b0;
      latch_code   <= FLT_NONE;
      last_beat    <= '0;
      status.valid <= 1'b0;
    end else begin
      if (hb_timeout_we) begin
        hb_timeout <= hb_timeout_wdata;
      end
      if (accept) begin
        estop_on     <= estop_on_next;
        driver_bad   <= driver_bad_next;
        power_low    <= power_low_next;
        comm_lost    <= comm_lost_next;
        latch_set    <= latch_set_next;
        latch_code   <= latch_code_next;
        last_beat    <= last_beat_next;
        status.valid <= 1'b1;
      end else if (status.ready) begin
        status.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status.fault_code   <= fault_next;
      status.latched_code <= latch_code_next;
      status.stop_latched <= latch_set_next;
      status.link_lost    <= comm_lost_next;
      status.motion_ok    <= !hard_fault && !comm_lost_next && !latch_set_next;
    end
  end

endmodule
`default_nettype wire
